[hw/rtl/tccot_pkg.sv]
// Shared constants and types of the triangle corner cotangent unit.
package tccot_pkg;

   localparam int COORD_WIDTH_DEF      = 24;
   localparam int RESULT_FRAC_BITS_DEF = 16;
   localparam int OUT_WIDTH            = 32;
   localparam int ROOT_BITS            = 32;
   localparam int QUOT_BITS            = 2 * ROOT_BITS;

   localparam logic [OUT_WIDTH-1:0] MAX_POS = 32'h7FFF_FFFF;
   localparam logic [OUT_WIDTH-1:0] MIN_NEG = 32'h8000_0000;

   // Control flags that travel with each transaction through the back pipeline.
   typedef struct packed {
      logic valid;
      logic degenerate;
      logic negative;
      logic overflow;
   } tag_type;

endpackage

[hw/rtl/tccot_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
module tccot_div #(
   parameter int NW = 104
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tccot_pkg::tag_type             in_tag,
   input  logic [NW-1:0]                  in_rem,
   input  logic [NW-1:0]                  in_div,
   input  logic [tccot_pkg::QUOT_BITS-1:0] in_low,
   output tccot_pkg::tag_type             out_tag,
   output logic [tccot_pkg::QUOT_BITS-1:0] out_quot
);

   localparam int QB = tccot_pkg::QUOT_BITS;

   tccot_pkg::tag_type tag_ff [QB];
   logic [NW-1:0]      rem_ff [QB];
   logic [NW-1:0]      div_ff [QB];
   logic [QB-1:0]      low_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_step
      tccot_pkg::tag_type tag_prev;
      logic [NW-1:0]      rem_prev;
      logic [NW-1:0]      div_prev;
      logic [QB-1:0]      low_prev;
      logic [NW:0]        trial;
      logic [NW:0]        diff;
      logic [NW-1:0]      rem_in;
      logic [QB-1:0]      low_in;

      if (k == 0) begin : g_first
         assign tag_prev = in_tag;
         assign rem_prev = in_rem;
         assign div_prev = in_div;
         assign low_prev = in_low;
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign div_prev = div_ff[k-1];
         assign low_prev = low_ff[k-1];
      end

      // Bring down the next dividend bit; the quotient bit fills in from the bottom.
      always_comb begin
         trial = {rem_prev, low_prev[QB-1]};
         diff  = trial - {1'b0, div_prev};
         if (trial >= {1'b0, div_prev}) begin
            rem_in = diff[NW-1:0];
            low_in = {low_prev[QB-2:0], 1'b1};
         end else begin
            rem_in = trial[NW-1:0];
            low_in = {low_prev[QB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_prev;
         end
         rem_ff[k] <= rem_in;
         div_ff[k] <= div_prev;
         low_ff[k] <= low_in;
      end
   end

   assign out_tag  = tag_ff[QB-1];
   assign out_quot = low_ff[QB-1];

endmodule

[hw/rtl/tccot_sqrt.sv]
// Pipelined integer square root: one root bit per stage.
module tccot_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  tccot_pkg::tag_type              in_tag,
   input  logic [tccot_pkg::QUOT_BITS-1:0] in_rad,
   output tccot_pkg::tag_type              out_tag,
   output logic [tccot_pkg::ROOT_BITS-1:0] out_root
);

   localparam int RB  = tccot_pkg::ROOT_BITS;
   localparam int QB  = tccot_pkg::QUOT_BITS;
   localparam int RMW = RB + 2;

   tccot_pkg::tag_type tag_ff  [RB];
   logic [RMW-1:0]     rem_ff  [RB];
   logic [RB-1:0]      root_ff [RB];
   logic [QB-1:0]      rad_ff  [RB];

   for (genvar k = 0; k < RB; k++) begin : g_step
      tccot_pkg::tag_type tag_prev;
      logic [RMW-1:0]     rem_prev;
      logic [RB-1:0]      root_prev;
      logic [QB-1:0]      rad_prev;
      logic [RMW+1:0]     rem2;
      logic [RMW+1:0]     trial;
      logic [RMW+1:0]     diff;
      logic [RMW-1:0]     rem_in;
      logic [RB-1:0]      root_in;

      if (k == 0) begin : g_first
         assign tag_prev  = in_tag;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
      end else begin : g_next
         assign tag_prev  = tag_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      always_comb begin
         rem2  = {rem_prev, rad_prev[QB-1:QB-2]};
         trial = (RMW+2)'({root_prev, 2'b01});
         diff  = rem2 - trial;
         if (rem2 >= trial) begin
            rem_in  = diff[RMW-1:0];
            root_in = {root_prev[RB-2:0], 1'b1};
         end else begin
            rem_in  = rem2[RMW-1:0];
            root_in = {root_prev[RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= {rad_prev[QB-3:0], 2'b00};
      end
   end

   assign out_tag  = tag_ff[RB-1];
   assign out_root = root_ff[RB-1];

endmodule

[hw/rtl/triangle_corner_cotangent_unit.sv]
// Top level of the triangle corner cotangent unit.
// This unit takes three points a, b and c and returns the cotangent of the triangle angle at
// corner b as dot(a-b, c-b) / |(a-b) x (c-b)|, truncated toward zero, in signed fixed point
// with RESULT_FRAC_BITS fraction bits. A new transaction is taken in every clock cycle; busy
// never rises. A transaction passes through 105 register stages, and its result is marked by a
// one-cycle rsp_valid strobe; results leave in the order the transactions came in. The stages
// are eight front stages (differences, products, sums, squares and the overflow check), a
// 64-stage restoring divider that forms the squared quotient, a 32-stage square root that
// yields one result bit per stage, and the output register.
// A degenerate triangle gives the largest positive value with rsp_degenerate set; a quotient
// outside the 32-bit range saturates with rsp_saturated set.
module triangle_corner_cotangent_unit #(
   parameter int COORD_WIDTH      = tccot_pkg::COORD_WIDTH_DEF,
   parameter int RESULT_FRAC_BITS = tccot_pkg::RESULT_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_a_x,
   input  logic signed [COORD_WIDTH-1:0]        req_a_y,
   input  logic signed [COORD_WIDTH-1:0]        req_a_z,
   input  logic signed [COORD_WIDTH-1:0]        req_b_x,
   input  logic signed [COORD_WIDTH-1:0]        req_b_y,
   input  logic signed [COORD_WIDTH-1:0]        req_b_z,
   input  logic signed [COORD_WIDTH-1:0]        req_c_x,
   input  logic signed [COORD_WIDTH-1:0]        req_c_y,
   input  logic signed [COORD_WIDTH-1:0]        req_c_z,
   output logic                                 rsp_valid,
   output logic signed [tccot_pkg::OUT_WIDTH-1:0] rsp_cot_value,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_saturated
);

   localparam int QB   = tccot_pkg::QUOT_BITS;
   localparam int RB   = tccot_pkg::ROOT_BITS;
   localparam int OW   = tccot_pkg::OUT_WIDTH;
   localparam int DW   = COORD_WIDTH + 1;           // edge vector component
   localparam int PW   = 2 * DW;                    // single product
   localparam int DOTW = PW + 2;                    // dot product, signed
   localparam int CXW  = PW + 1;                    // cross product component, signed
   localparam int MW   = DOTW;                      // dot product magnitude
   localparam int HC   = (CXW + 1) / 2;             // low half of a cross magnitude
   localparam int HCH  = CXW - HC;                  // high half of a cross magnitude
   localparam int HD   = (MW + 1) / 2;
   localparam int HDH  = MW - HD;
   localparam int NW   = 2 * CXW + 2;               // squared cross length
   localparam int TW   = 2 * MW + 2 * RESULT_FRAC_BITS;
   localparam int TPW  = (TW > QB) ? TW : QB + 1;   // scaled squared dot, padded
   localparam int HIW  = TPW - QB;
   localparam int CMPW = HIW + NW;

   // The receiver cannot stall and every stage advances each cycle.
   assign busy = 1'b0;

   // Stage 1: edge vectors u = a - b and v = c - b.
   logic                 v1_ff;
   logic signed [DW-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      ux_ff <= DW'(req_a_x) - DW'(req_b_x);
      uy_ff <= DW'(req_a_y) - DW'(req_b_y);
      uz_ff <= DW'(req_a_z) - DW'(req_b_z);
      vx_ff <= DW'(req_c_x) - DW'(req_b_x);
      vy_ff <= DW'(req_c_y) - DW'(req_b_y);
      vz_ff <= DW'(req_c_z) - DW'(req_b_z);
   end

   // Stage 2: the nine component products.
   logic                 v2_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pzz_ff;
   logic signed [PW-1:0] pyz_ff, pzy_ff, pzx_ff, pxz_ff, pxy_ff, pyx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pxx_ff <= PW'(ux_ff) * PW'(vx_ff);
      pyy_ff <= PW'(uy_ff) * PW'(vy_ff);
      pzz_ff <= PW'(uz_ff) * PW'(vz_ff);
      pyz_ff <= PW'(uy_ff) * PW'(vz_ff);
      pzy_ff <= PW'(uz_ff) * PW'(vy_ff);
      pzx_ff <= PW'(uz_ff) * PW'(vx_ff);
      pxz_ff <= PW'(ux_ff) * PW'(vz_ff);
      pxy_ff <= PW'(ux_ff) * PW'(vy_ff);
      pyx_ff <= PW'(uy_ff) * PW'(vx_ff);
   end

   // Stage 3: dot product and cross product.
   logic                   v3_ff;
   logic signed [DOTW-1:0] dot_ff;
   logic signed [CXW-1:0]  cx_ff, cy_ff, cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      dot_ff <= DOTW'(pxx_ff) + DOTW'(pyy_ff) + DOTW'(pzz_ff);
      cx_ff  <= CXW'(pyz_ff) - CXW'(pzy_ff);
      cy_ff  <= CXW'(pzx_ff) - CXW'(pxz_ff);
      cz_ff  <= CXW'(pxy_ff) - CXW'(pyx_ff);
   end

   // Stage 4: magnitudes, since only squares follow; the dot sign is kept aside.
   logic           v4_ff, neg4_ff;
   logic [MW-1:0]  dmag_ff;
   logic [CXW-1:0] mx_ff, my_ff, mz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      neg4_ff <= dot_ff[DOTW-1];
      dmag_ff <= dot_ff[DOTW-1] ? MW'(-dot_ff) : MW'(dot_ff);
      mx_ff   <= cx_ff[CXW-1] ? CXW'(-cx_ff) : CXW'(cx_ff);
      my_ff   <= cy_ff[CXW-1] ? CXW'(-cy_ff) : CXW'(cy_ff);
      mz_ff   <= cz_ff[CXW-1] ? CXW'(-cz_ff) : CXW'(cz_ff);
   end

   // Stage 5: half-width partial products of the four squares.
   logic                v5_ff, neg5_ff;
   logic [2*HCH-1:0]    xhh_ff, yhh_ff, zhh_ff;
   logic [HCH+HC-1:0]   xhl_ff, yhl_ff, zhl_ff;
   logic [2*HC-1:0]     xll_ff, yll_ff, zll_ff;
   logic [2*HDH-1:0]    dhh_ff;
   logic [HDH+HD-1:0]   dhl_ff;
   logic [2*HD-1:0]     dll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      neg5_ff <= neg4_ff;
      xhh_ff  <= (2*HCH)'(mx_ff[CXW-1:HC]) * (2*HCH)'(mx_ff[CXW-1:HC]);
      xhl_ff  <= (HCH+HC)'(mx_ff[CXW-1:HC]) * (HCH+HC)'(mx_ff[HC-1:0]);
      xll_ff  <= (2*HC)'(mx_ff[HC-1:0]) * (2*HC)'(mx_ff[HC-1:0]);
      yhh_ff  <= (2*HCH)'(my_ff[CXW-1:HC]) * (2*HCH)'(my_ff[CXW-1:HC]);
      yhl_ff  <= (HCH+HC)'(my_ff[CXW-1:HC]) * (HCH+HC)'(my_ff[HC-1:0]);
      yll_ff  <= (2*HC)'(my_ff[HC-1:0]) * (2*HC)'(my_ff[HC-1:0]);
      zhh_ff  <= (2*HCH)'(mz_ff[CXW-1:HC]) * (2*HCH)'(mz_ff[CXW-1:HC]);
      zhl_ff  <= (HCH+HC)'(mz_ff[CXW-1:HC]) * (HCH+HC)'(mz_ff[HC-1:0]);
      zll_ff  <= (2*HC)'(mz_ff[HC-1:0]) * (2*HC)'(mz_ff[HC-1:0]);
      dhh_ff  <= (2*HDH)'(dmag_ff[MW-1:HD]) * (2*HDH)'(dmag_ff[MW-1:HD]);
      dhl_ff  <= (HDH+HD)'(dmag_ff[MW-1:HD]) * (HDH+HD)'(dmag_ff[HD-1:0]);
      dll_ff  <= (2*HD)'(dmag_ff[HD-1:0]) * (2*HD)'(dmag_ff[HD-1:0]);
   end

   // Stage 6: squares assembled from their partial products.
   logic              v6_ff, neg6_ff;
   logic [2*CXW-1:0]  sx_ff, sy_ff, sz_ff;
   logic [2*MW-1:0]   dsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      neg6_ff <= neg5_ff;
      sx_ff  <= ((2*CXW)'(xhh_ff) << (2*HC)) + ((2*CXW)'(xhl_ff) << (HC+1))
              + (2*CXW)'(xll_ff);
      sy_ff  <= ((2*CXW)'(yhh_ff) << (2*HC)) + ((2*CXW)'(yhl_ff) << (HC+1))
              + (2*CXW)'(yll_ff);
      sz_ff  <= ((2*CXW)'(zhh_ff) << (2*HC)) + ((2*CXW)'(zhl_ff) << (HC+1))
              + (2*CXW)'(zll_ff);
      dsq_ff <= ((2*MW)'(dhh_ff) << (2*HD)) + ((2*MW)'(dhl_ff) << (HD+1))
              + (2*MW)'(dll_ff);
   end

   // Stage 7: squared cross length N and scaled squared dot T.
   logic           v7_ff, neg7_ff;
   logic [NW-1:0]  nsq_ff;
   logic [TPW-1:0] tsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      neg7_ff <= neg6_ff;
      nsq_ff  <= NW'(sx_ff) + NW'(sy_ff) + NW'(sz_ff);
      tsq_ff  <= TPW'(dsq_ff) << (2 * RESULT_FRAC_BITS);
   end

   // Stage 8: the result is the square root of floor(T / N). A quotient of 2^64 or more
   // means the result needs more than 32 bits, which is caught here before the divider.
   tccot_pkg::tag_type tag8_ff;
   logic [NW-1:0]      rem8_ff;
   logic [NW-1:0]      div8_ff;
   logic [QB-1:0]      low8_ff;
   logic [HIW-1:0]     t_hi;

   assign t_hi = tsq_ff[TPW-1:QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag8_ff <= '0;
      end else begin
         tag8_ff.valid      <= v7_ff;
         tag8_ff.degenerate <= (nsq_ff == '0);
         tag8_ff.negative   <= neg7_ff;
         tag8_ff.overflow   <= (CMPW'(t_hi) >= CMPW'(nsq_ff));
      end
      rem8_ff <= NW'(t_hi);
      div8_ff <= nsq_ff;
      low8_ff <= tsq_ff[QB-1:0];
   end

   tccot_pkg::tag_type div_tag;
   logic [QB-1:0]      div_quot;

   tccot_div #(
      .NW(NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (tag8_ff),
      .in_rem   (rem8_ff),
      .in_div   (div8_ff),
      .in_low   (low8_ff),
      .out_tag  (div_tag),
      .out_quot (div_quot)
   );

   tccot_pkg::tag_type sqrt_tag;
   logic [RB-1:0]      sqrt_root;

   tccot_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (div_tag),
      .in_rad   (div_quot),
      .out_tag  (sqrt_tag),
      .out_root (sqrt_root)
   );

   // Output stage: sign, saturation and the degenerate case.
   logic          rsp_valid_ff;
   logic [OW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_deg_ff, rsp_deg_in;
   logic          rsp_sat_ff, rsp_sat_in;

   always_comb begin
      rsp_value_in = sqrt_root;
      rsp_deg_in   = 1'b0;
      rsp_sat_in   = 1'b0;
      if (sqrt_tag.degenerate) begin
         rsp_value_in = tccot_pkg::MAX_POS;
         rsp_deg_in   = 1'b1;
      end else if (!sqrt_tag.negative) begin
         if (sqrt_tag.overflow || sqrt_root > tccot_pkg::MAX_POS) begin
            rsp_value_in = tccot_pkg::MAX_POS;
            rsp_sat_in   = 1'b1;
         end
      end else begin
         if (sqrt_tag.overflow || sqrt_root > tccot_pkg::MIN_NEG) begin
            rsp_value_in = tccot_pkg::MIN_NEG;
            rsp_sat_in   = 1'b1;
         end else begin
            rsp_value_in = OW'(-sqrt_root);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sqrt_tag.valid;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_deg_ff   <= rsp_deg_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cot_value  = rsp_value_ff;
   assign rsp_degenerate = rsp_deg_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // A degenerate result is never also reported as saturated and carries the top value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_saturated && rsp_cot_value == tccot_pkg::MAX_POS)
      else $error("degenerate result has wrong value or flags");

   // A saturated result sits on one of the two range limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_cot_value == tccot_pkg::MAX_POS || rsp_cot_value == tccot_pkg::MIN_NEG)
      else $error("saturated result is not at a range limit");

   // A transaction leaving the front pipeline emerges at the output after the back stages.
   assert property (@(posedge clock) disable iff (reset)
      tag8_ff.valid |-> ##(QB + RB + 1) rsp_valid)
      else $error("transaction lost in the divider or root pipeline");

endmodule

[tb/sv/tb_triangle_corner_cotangent_unit.sv]
// Self-checking testbench for the triangle corner cotangent unit.
`timescale 1ns / 1ps

module tb_triangle_corner_cotangent_unit;

   localparam int CW          = tccot_pkg::COORD_WIDTH_DEF;
   localparam int FRAC        = tccot_pkg::RESULT_FRAC_BITS_DEF;
   localparam int OWD         = tccot_pkg::OUT_WIDTH;
   localparam int LATENCY     = 105;
   localparam int RANDOM_TXNS = 1630;
   localparam int STALL_LIMIT = 4000;

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [255:0]   wide_type;

   // One expected result of the cotangent unit.
   typedef struct packed {
      logic [OWD-1:0] cot;
      logic           degen;
      logic           sat;
   } cot_result_type;

   // One row of the directed stimulus. Rows with known set carry a result
   // that is checked against the predictor before the transaction is sent.
   typedef struct {
      coord_type      pt[9];
      logic           known;
      cot_result_type res;
   } corner_row_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   coord_type pt_drv[9];
   logic      rsp_valid;
   logic signed [OWD-1:0] rsp_cot_value;
   logic      rsp_degenerate;
   logic      rsp_saturated;

   cot_result_type pending_cot[$];
   int             mismatches;
   int             results_seen;
   int             degen_seen;
   int             sat_seen;
   int             idle_cycles;
   logic           sent_all;

   triangle_corner_cotangent_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_a_x       (pt_drv[0]),
      .req_a_y       (pt_drv[1]),
      .req_a_z       (pt_drv[2]),
      .req_b_x       (pt_drv[3]),
      .req_b_y       (pt_drv[4]),
      .req_b_z       (pt_drv[5]),
      .req_c_x       (pt_drv[6]),
      .req_c_y       (pt_drv[7]),
      .req_c_z       (pt_drv[8]),
      .rsp_valid     (rsp_valid),
      .rsp_cot_value (rsp_cot_value),
      .rsp_degenerate(rsp_degenerate),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact cotangent at corner b. The edge vectors u = a - b and v = c - b are
   // formed at full width, so that the dot product D and the squared cross
   // length N are exact. The magnitude is the largest q with
   // q*q*N <= D*D*2^(2*FRAC), found one bit at a time from the top.
   function automatic cot_result_type predict_cot(input coord_type p[9]);
      wide_type       ux, uy, uz, vx, vy, vz;
      wide_type       dot, crx, cry, crz, nsq, mag, target, trial;
      logic [63:0]    q;
      logic           neg;
      cot_result_type r;
      ux = wide_type'(p[0]) - wide_type'(p[3]);
      uy = wide_type'(p[1]) - wide_type'(p[4]);
      uz = wide_type'(p[2]) - wide_type'(p[5]);
      vx = wide_type'(p[6]) - wide_type'(p[3]);
      vy = wide_type'(p[7]) - wide_type'(p[4]);
      vz = wide_type'(p[8]) - wide_type'(p[5]);
      dot = ux * vx + uy * vy + uz * vz;
      crx = uy * vz - uz * vy;
      cry = uz * vx - ux * vz;
      crz = ux * vy - uy * vx;
      nsq = crx * crx + cry * cry + crz * crz;
      r.degen = 1'b0;
      r.sat   = 1'b0;
      if (nsq == 0) begin
         // A degenerate triangle pins the result high, whatever the dot sign.
         r.cot   = tccot_pkg::MAX_POS;
         r.degen = 1'b1;
         return r;
      end
      neg    = dot < 0;
      mag    = neg ? -dot : dot;
      target = (mag * mag) <<< (2 * FRAC);
      q = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = wide_type'(q | (64'd1 << i));
         if ($unsigned(trial * trial * nsq) <= $unsigned(target))
            q = q | (64'd1 << i);
      end
      if (!neg) begin
         if (q > 64'h7FFF_FFFF) begin
            q     = 64'h7FFF_FFFF;
            r.sat = 1'b1;
         end
         r.cot = q[31:0];
      end else begin
         if (q > 64'h8000_0000) begin
            q     = 64'h8000_0000;
            r.sat = 1'b1;
         end
         r.cot = 32'(-q);
      end
      return r;
   endfunction

   // Drives one transaction at the falling edge and holds it until the unit
   // takes it. The expectation is queued at the accepting rising edge.
   task automatic send_corner(input coord_type p[9]);
      @(negedge clock);
      pt_drv = p;
      start  = 1'b1;
      do @(posedge clock); while (busy);
      pending_cot.push_back(predict_cot(p));
   endtask

   // Random idle time on the request side: mostly none or short, a few long.
   task automatic sender_gap();
      int n;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) n = 0;
      else if (pick < 92) n = $urandom_range(1, 4);
      else n = $urandom_range(10, 150);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   function automatic coord_type rand_small(input int span);
      return coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   // Builds one random corner. Fully random points dominate; small shapes,
   // collinear points, right angles and near-flat triangles reach the
   // degenerate and saturating branches that random points rarely hit.
   function automatic void make_corner(output coord_type p[9]);
      int mode;
      int k;
      mode = $urandom_range(0, 99);
      for (int i = 0; i < 9; i++) p[i] = rand_coord();
      if (mode < 40) begin
         // Fully random points, every coordinate bit free.
      end else if (mode < 65) begin
         for (int i = 0; i < 9; i++) p[i] = rand_small(20000);
      end else if (mode < 75) begin
         // c lies on the line through b and a.
         for (int i = 0; i < 6; i++) p[i] = rand_small(100000);
         k = $urandom_range(0, 8) - 4;
         for (int i = 0; i < 3; i++)
            p[6 + i] = coord_type'(p[3 + i] + k * (p[i] - p[3 + i]));
      end else if (mode < 85) begin
         // Nearly flat: c is a tiny step off the line through b and a.
         for (int i = 0; i < 6; i++) p[i] = rand_small(1000000);
         k = ($urandom_range(0, 1) != 0) ? 1 : -1;
         for (int i = 0; i < 3; i++)
            p[6 + i] = coord_type'(p[3 + i] + k * (p[i] - p[3 + i]) + rand_small(1));
      end else if (mode < 92) begin
         // Right angle in the xy plane around b, up to small noise.
         for (int i = 3; i < 6; i++) p[i] = rand_small(1000000);
         p[0] = p[3] + rand_small(500000);
         p[1] = p[4];
         p[2] = p[5];
         p[6] = p[3] + rand_small(2);
         p[7] = p[4] + rand_small(500000);
         p[8] = p[5];
      end else begin
         // Coordinates at the ends of the range.
         for (int i = 0; i < 9; i++)
            case ($urandom_range(0, 3))
               0: p[i] = {1'b0, {(CW-1){1'b1}}};
               1: p[i] = {1'b1, {(CW-1){1'b0}}};
               2: p[i] = '0;
               default: p[i] = rand_coord();
            endcase
      end
   endfunction

   function automatic corner_row_type row(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                          input logic known = 1'b0,
                                          input logic [31:0] cot = '0,
                                          input logic degen = 1'b0,
                                          input logic sat = 1'b0);
      corner_row_type r;
      r.pt = '{coord_type'(ax), coord_type'(ay), coord_type'(az), coord_type'(bx),
               coord_type'(by), coord_type'(bz), coord_type'(cx), coord_type'(cy),
               coord_type'(cz)};
      r.known     = known;
      r.res.cot   = cot;
      r.res.degen = degen;
      r.res.sat   = sat;
      return r;
   endfunction

   // Response checker and stall watchdog. The unit cannot hold results off,
   // so every strobe is a transaction and is matched against the oldest
   // expectation. The watchdog counts cycles in which no transaction moved
   // on either side.
   always @(posedge clock) begin
      cot_result_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("triangle_corner_cotangent_unit: mismatch");
            $finish;
         end
         if (rsp_valid) begin
            results_seen <= results_seen + 1;
            if (rsp_degenerate) degen_seen <= degen_seen + 1;
            if (rsp_saturated) sat_seen <= sat_seen + 1;
            if (pending_cot.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected result cot=%h degen=%b sat=%b",
                           rsp_cot_value, rsp_degenerate, rsp_saturated);
            end else begin
               want = pending_cot.pop_front();
               if (rsp_cot_value !== want.cot || rsp_degenerate !== want.degen ||
                   rsp_saturated !== want.sat) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("result %0d: expected cot=%h degen=%b sat=%b, got %h %b %b",
                              results_seen, want.cot, want.degen, want.sat,
                              rsp_cot_value, rsp_degenerate, rsp_saturated);
               end
            end
         end
      end
   end

   initial begin
      corner_row_type rows[$];
      coord_type      p[9];
      cot_result_type model;
      int             wait_cycles;
      localparam int ONE  = 1 << 12;
      localparam int MAXC = (1 << (CW - 1)) - 1;
      localparam int MINC = -(1 << (CW - 1));

      start        = 1'b0;
      reset        = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      degen_seen   = 0;
      sat_seen     = 0;
      idle_cycles  = 0;
      sent_all     = 1'b0;
      for (int i = 0; i < 9; i++) pt_drv[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: coincident points, simple angles, both saturations,
      // collinear points with either dot sign and the coordinate extremes.
      rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0,
                         1'b1, tccot_pkg::MAX_POS, 1'b1, 1'b0));
      rows.push_back(row(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, 1'b1, 32'h0, 1'b0, 1'b0));
      rows.push_back(row(ONE, 0, 0, 0, 0, 0, ONE, ONE, 0,
                         1'b1, 32'h0001_0000, 1'b0, 1'b0));
      rows.push_back(row(ONE, 0, 0, 0, 0, 0, -ONE, ONE, 0,
                         1'b1, 32'hFFFF_0000, 1'b0, 1'b0));
      rows.push_back(row(MAXC, 0, 0, 0, 0, 0, MAXC, 1, 0,
                         1'b1, tccot_pkg::MAX_POS, 1'b0, 1'b1));
      rows.push_back(row(MAXC, 0, 0, 0, 0, 0, MINC, 1, 0,
                         1'b1, tccot_pkg::MIN_NEG, 1'b0, 1'b1));
      rows.push_back(row(ONE, ONE, 0, 0, 0, 0, -ONE, -ONE, 0,
                         1'b1, tccot_pkg::MAX_POS, 1'b1, 1'b0));
      rows.push_back(row(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC,
                         1'b1, tccot_pkg::MAX_POS, 1'b1, 1'b0));
      rows.push_back(row(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC,
                         1'b1, tccot_pkg::MAX_POS, 1'b1, 1'b0));
      rows.push_back(row(MAXC, MINC, 0, MINC, MAXC, MINC, 0, MAXC, MAXC));
      rows.push_back(row(MINC, MAXC, MINC, 0, 0, 0, MAXC, MINC, MAXC));
      rows.push_back(row(MAXC, 0, 0, MINC, 0, 0, MINC, MAXC, 0));
      rows.push_back(row(-1, -1, -1, 0, 0, 0, 1, -1, 1));
      rows.push_back(row(3 * ONE, 0, 0, 0, 0, 0, ONE, 2 * ONE, 5 * ONE));
      rows.push_back(row(0, 0, ONE, ONE, ONE, ONE, ONE, 0, 0));
      rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 1, 0, 1'b1, 32'h0, 1'b0, 1'b0));
      rows.push_back(row(MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MINC));

      foreach (rows[i]) begin
         if (rows[i].known) begin
            model = predict_cot(rows[i].pt);
            if (model !== rows[i].res) begin
               mismatches = mismatches + 1;
               $display("directed row %0d: table says %h %b %b, predictor says %h %b %b",
                        i, rows[i].res.cot, rows[i].res.degen, rows[i].res.sat,
                        model.cot, model.degen, model.sat);
            end
         end
         send_corner(rows[i].pt);
         if (i % 5 == 4) sender_gap();
      end

      for (int n = 0; n < RANDOM_TXNS; n++) begin
         make_corner(p);
         send_corner(p);
         // Hold back once, mid-run, until the whole pipeline has drained.
         if (n == RANDOM_TXNS / 2) begin
            @(negedge clock);
            start = 1'b0;
            while (pending_cot.size() != 0) @(negedge clock);
         end else if (n % 200 >= 100) begin
            sender_gap();
         end
      end
      @(negedge clock);
      start    = 1'b0;
      sent_all = 1'b1;

      wait_cycles = 0;
      while (pending_cot.size() != 0 && wait_cycles < 20 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * LATENCY) @(posedge clock);

      $display("Sent %0d corners: directed table plus random, collinear and flat shapes.",
               rows.size() + RANDOM_TXNS);
      $display("Checked %0d results, %0d degenerate and %0d saturated.",
               results_seen, degen_seen, sat_seen);
      if (mismatches == 0 && pending_cot.size() == 0) begin
         $display("triangle_corner_cotangent_unit: match");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
                  pending_cot.size());
         $display("triangle_corner_cotangent_unit: mismatch");
      end
      $finish;
   end

endmodule
